FILE: hw/rtl/conv3_pkg.sv
package conv3_pkg;

    localparam int PIX_W      = 8;
    localparam int FW_W       = 11;
    localparam int HGT_W      = 12;
    localparam int DIV_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int SUM_W      = 21;
    localparam int QUO_W      = 20;
    localparam int PIX_MAX    = 255;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_MIDDLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HGT   = 3'd5;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    typedef logic [8:0][PIX_W-1:0] t_win;

    typedef struct packed {
        logic             func;
        logic [PIX_W-1:0] pixel_value;
    } t_in;

    typedef struct packed {
        logic [PIX_W-1:0] out_pixel;
        logic             end_of_frame;
    } t_out;

    typedef struct packed {
        logic             conv;
        logic [PIX_W-1:0] value;
        logic             eof;
        t_win             win;
    } t_job;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic {
        F_IDLE,
        F_PROC
    } t_front_st;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MAC,
        B_DIV,
        B_OUT
    } t_back_st;

endpackage

FILE: hw/rtl/convolution_3x3_divide_clamp.sv
// Path: a border or drain transfer goes through the front's item register, the job
// queue and the back end's output register; an interior pixel also passes the
// multiply-accumulate and bit-serial divide states. The front reads the line store,
// then updates it, before it takes the next item; the back end holds one job at a time.
// Reset: synchronous active low; registers return to defaults, counters to zero,
// line store contents stay undefined until written.
module convolution_3x3_divide_clamp #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  conv3_pkg::t_in                   i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output conv3_pkg::t_out                  o_out_data,
    input  logic                             i_cfg_we,
    input  logic [conv3_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [conv3_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import conv3_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = 14;

    logic [CFG_DATA_W-1:0] r_coef_top;
    logic [CFG_DATA_W-1:0] r_coef_mid;
    logic [CFG_DATA_W-1:0] r_coef_bot;
    logic [DIV_W-1:0]      r_divisor;
    logic [FW_W-1:0]       r_width;
    logic [HGT_W-1:0]      r_height;
    logic                  restart;
    logic [COL_W-1:0]      width_eff;
    logic [HGT_W-1:0]      height_eff;
    t_job                  push_job;
    t_job                  pop_job;
    t_q_ctrl               q_ctrl;
    t_q_stat               q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_top <= '0;
            r_coef_mid <= CFG_DATA_W'(256);
            r_coef_bot <= '0;
            r_divisor  <= DIV_W'(1);
            r_width    <= FW_W'(640);
            r_height   <= HGT_W'(480);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_COEF_TOP:    r_coef_top <= i_cfg_data;
                REG_COEF_MIDDLE: r_coef_mid <= i_cfg_data;
                REG_COEF_BOTTOM: r_coef_bot <= i_cfg_data;
                REG_DIVISOR:     r_divisor  <= i_cfg_data[DIV_W-1:0];
                REG_FRAME_WIDTH: r_width    <= i_cfg_data[FW_W-1:0];
                REG_FRAME_HGT:   r_height   <= i_cfg_data[HGT_W-1:0];
                default: ;
            endcase
        end
    end

    assign restart = i_cfg_we
                  && (i_cfg_index == REG_FRAME_WIDTH || i_cfg_index == REG_FRAME_HGT);

    always_comb begin
        if (CMP_W'(r_width) < CMP_W'(3)) begin
            width_eff = COL_W'(3);
        end else if (CMP_W'(r_width) > CMP_W'(MAX_WIDTH)) begin
            width_eff = COL_W'(MAX_WIDTH);
        end else begin
            width_eff = COL_W'(r_width);
        end
        height_eff = (r_height == '0) ? HGT_W'(1) : r_height;
    end

    conv3_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_restart  (restart),
        .i_width    (width_eff),
        .i_height   (height_eff),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_stat.full),
        .o_push     (q_ctrl.push),
        .o_job      (push_job)
    );

    conv3_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (q_ctrl),
        .i_job   (push_job),
        .o_job   (pop_job),
        .o_stat  (q_stat)
    );

    conv3_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_coef_top  (r_coef_top),
        .i_coef_mid  (r_coef_mid),
        .i_coef_bot  (r_coef_bot),
        .i_divisor   (r_divisor),
        .i_job       (pop_job),
        .i_q_empty   (q_stat.empty),
        .o_pop       (q_ctrl.pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );
endmodule

FILE: hw/rtl/conv3_queue.sv
module conv3_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  conv3_pkg::t_q_ctrl i_ctrl,
    input  conv3_pkg::t_job    i_job,
    output conv3_pkg::t_job    o_job,
    output conv3_pkg::t_q_stat o_stat
);
    import conv3_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    t_job               r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [PTR_W:0]     r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_ctrl.push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_ctrl.pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_ctrl.push && !i_ctrl.pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_ctrl.push && i_ctrl.pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_job        = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_stat.empty = (r_count == '0);
endmodule

FILE: hw/rtl/conv3_front.sv
module conv3_front #(
    parameter  int MAX_WIDTH = 1024,
    localparam int COL_W     = $clog2(MAX_WIDTH + 1),
    localparam int ADDR_W    = $clog2(MAX_WIDTH)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_restart,
    input  logic [COL_W-1:0]             i_width,
    input  logic [conv3_pkg::HGT_W-1:0]  i_height,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  conv3_pkg::t_in               i_in_data,
    input  logic                         i_q_full,
    output logic                         o_push,
    output conv3_pkg::t_job              o_job
);
    import conv3_pkg::*;

    t_front_st          r_state;
    t_front_st          n_state;
    t_in                r_item;
    logic [PIX_W-1:0]   r_up_rd;
    logic [PIX_W-1:0]   r_lo_rd;
    logic [PIX_W-1:0]   r_corner;
    t_win               r_win;
    logic [COL_W-1:0]   r_in_col;
    logic [HGT_W-1:0]   r_in_row;
    logic [COL_W-1:0]   r_out_col;
    logic [HGT_W-1:0]   r_out_row;
    logic [PIX_W-1:0]   mem_upper [MAX_WIDTH];
    logic [PIX_W-1:0]   mem_lower [MAX_WIDTH];

    logic               accept;
    logic               done;
    logic               is_pixel;
    logic               emit;
    logic               interior;
    logic               last_out;
    logic               wrap_in;
    logic               do_pixel;
    logic               do_drain;
    logic [ADDR_W-1:0]  rd_addr;
    t_win               win_next;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == F_IDLE) && !i_q_full;
    assign rd_addr    = (i_in_data.func == FUNC_DRAIN) ? r_out_col[ADDR_W-1:0]
                                                       : r_in_col[ADDR_W-1:0];

    assign done     = (r_in_row >= i_height);
    assign is_pixel = (r_item.func == FUNC_PIXEL);
    assign do_pixel = (r_state == F_PROC) && is_pixel && !done;
    assign do_drain = (r_state == F_PROC) && !is_pixel && done;
    assign emit     = (r_in_col != '0) ? (r_in_row >= HGT_W'(1)) : (r_in_row >= HGT_W'(2));
    assign interior = (r_out_row != '0)
                   && (({1'b0, r_out_row} + (HGT_W+1)'(2)) <= {1'b0, i_height})
                   && (r_out_col != '0)
                   && (({1'b0, r_out_col} + (COL_W+1)'(2)) <= {1'b0, i_width});
    assign last_out = (r_out_row == i_height - 1'b1) && (r_out_col == i_width - 1'b1);
    assign wrap_in  = (({1'b0, r_in_col} + (COL_W+1)'(1)) >= {1'b0, i_width});

    always_comb begin
        win_next    = r_win;
        win_next[0] = r_win[1];
        win_next[1] = r_win[2];
        win_next[3] = r_win[4];
        win_next[4] = r_win[5];
        win_next[6] = r_win[7];
        win_next[7] = r_win[8];
        win_next[2] = r_up_rd;
        win_next[5] = r_lo_rd;
        win_next[8] = r_item.pixel_value;
    end

    always_comb begin
        n_state   = r_state;
        o_push    = 1'b0;
        o_job     = '0;
        o_job.win = win_next;
        o_job.eof = last_out;
        unique case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_state = F_PROC;
                end
            end
            F_PROC: begin
                n_state = F_IDLE;
                if (do_pixel && emit) begin
                    o_push = 1'b1;
                    if (r_in_col == '0) begin
                        o_job.value = r_corner;
                    end else if (interior) begin
                        o_job.conv = 1'b1;
                    end else begin
                        o_job.value = win_next[4];
                    end
                end else if (do_drain) begin
                    o_push      = 1'b1;
                    o_job.value = (r_out_row == i_height - 1'b1) ? r_lo_rd : r_up_rd;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item  <= i_in_data;
            r_up_rd <= mem_upper[rd_addr];
            r_lo_rd <= mem_lower[rd_addr];
        end
        if (do_pixel) begin
            mem_upper[r_in_col[ADDR_W-1:0]] <= r_lo_rd;
            mem_lower[r_in_col[ADDR_W-1:0]] <= r_item.pixel_value;
            if (r_in_col == i_width - 1'b1) begin
                r_corner <= r_lo_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win     <= '0;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (i_restart) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            if (do_pixel) begin
                r_win <= win_next;
                if (wrap_in) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + 1'b1;
                end else begin
                    r_in_col <= r_in_col + 1'b1;
                end
            end
            if ((do_pixel && emit) || do_drain) begin
                if (last_out) begin
                    r_in_col  <= '0;
                    r_in_row  <= '0;
                    r_out_col <= '0;
                    r_out_row <= '0;
                end else if (({1'b0, r_out_col} + (COL_W+1)'(1)) >= {1'b0, i_width}) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + 1'b1;
                end else begin
                    r_out_col <= r_out_col + 1'b1;
                end
            end
        end
    end
endmodule

FILE: hw/rtl/conv3_back.sv
module conv3_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [conv3_pkg::CFG_DATA_W-1:0] i_coef_top,
    input  logic [conv3_pkg::CFG_DATA_W-1:0] i_coef_mid,
    input  logic [conv3_pkg::CFG_DATA_W-1:0] i_coef_bot,
    input  logic [conv3_pkg::DIV_W-1:0]      i_divisor,
    input  conv3_pkg::t_job                  i_job,
    input  logic                             i_q_empty,
    output logic                             o_pop,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output conv3_pkg::t_out                  o_out_data
);
    import conv3_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);

    t_back_st                r_state;
    t_back_st                n_state;
    t_win                    r_win;
    logic                    r_eof;
    logic [1:0]              r_row;
    logic signed [SUM_W-1:0] r_acc;
    logic [QUO_W-1:0]        r_quo;
    logic [DIV_W-1:0]        r_rem;
    logic [CNT_W-1:0]        r_cnt;
    logic [PIX_W-1:0]        r_res;
    logic                    r_out_valid;
    t_out                    r_out;

    logic [CFG_DATA_W-1:0]   coef_row;
    logic signed [SUM_W-1:0] row_sum;
    logic [DIV_W:0]          trial;
    logic [DIV_W:0]          dvs;
    logic                    slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign dvs         = (i_divisor == '0) ? (DIV_W+1)'(1) : {1'b0, i_divisor};
    assign trial       = {r_rem, r_quo[QUO_W-1]};

    always_comb begin
        case (r_row)
            2'd0:    coef_row = i_coef_top;
            2'd1:    coef_row = i_coef_mid;
            default: coef_row = i_coef_bot;
        endcase
        row_sum = SUM_W'($signed(coef_row[7:0]))   * SUM_W'($signed({1'b0, r_win[0]}))
                + SUM_W'($signed(coef_row[15:8]))  * SUM_W'($signed({1'b0, r_win[1]}))
                + SUM_W'($signed(coef_row[23:16])) * SUM_W'($signed({1'b0, r_win[2]}));
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_state = i_job.conv ? B_MAC : B_OUT;
                end
            end
            B_MAC: begin
                if (r_row == 2'd2) begin
                    n_state = B_DIV;
                end
            end
            B_DIV: begin
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    n_state = B_OUT;
                end
            end
            B_OUT: begin
                if (slot_free) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_OUT && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_win <= i_job.win;
                r_eof <= i_job.eof;
                r_res <= i_job.value;
                r_row <= '0;
                r_acc <= '0;
            end
            B_MAC: begin
                r_acc <= r_acc + row_sum;
                r_win <= t_win'(r_win >> (3 * PIX_W));
                r_row <= r_row + 1'b1;
                if (r_row == 2'd2) begin
                    r_quo <= ((r_acc + row_sum) > 0) ? QUO_W'(r_acc + row_sum) : '0;
                    r_rem <= '0;
                    r_cnt <= '0;
                end
            end
            B_DIV: begin
                r_cnt <= r_cnt + 1'b1;
                if (trial >= dvs) begin
                    r_rem <= DIV_W'(trial - dvs);
                    r_quo <= {r_quo[QUO_W-2:0], 1'b1};
                end else begin
                    r_rem <= trial[DIV_W-1:0];
                    r_quo <= {r_quo[QUO_W-2:0], 1'b0};
                end
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    r_res <= '1;
                end
            end
            B_OUT: begin
                if (slot_free) begin
                    r_out.out_pixel    <= (r_row == 2'd3 && r_quo <= QUO_W'(PIX_MAX))
                                        ? r_quo[PIX_W-1:0] : r_res;
                    r_out.end_of_frame <= r_eof;
                end
            end
            default: ;
        endcase
    end
endmodule

FILE: test/convolution_3x3_divide_clamp_tb.sv
module convolution_3x3_divide_clamp_tb;
    import conv3_pkg::*;

    localparam int MAX_W      = 1024;
    localparam int CYCLE_CAP  = 3000000;
    localparam int SETTLE_CYC = 40;

    class filter_board;
        logic [7:0]  upper_row [MAX_W];
        logic [7:0]  lower_row [MAX_W];
        logic [7:0]  window [9];
        logic [23:0] coef [3];
        logic [7:0]  divisor;
        logic [10:0] width_reg;
        logic [11:0] height_reg;
        int unsigned in_col, in_row, out_col, out_row;
        t_out        pending[$];
        int          mismatches;
        int          checked;

        function new();
            coef[0] = 24'd0;
            coef[1] = 24'd256;
            coef[2] = 24'd0;
            divisor = 8'd1;
            width_reg = 11'd640;
            height_reg = 12'd480;
            foreach (upper_row[k]) begin
                upper_row[k] = '0;
                lower_row[k] = '0;
            end
            foreach (window[k]) window[k] = '0;
            restart();
            mismatches = 0;
            checked = 0;
        endfunction

        function void restart();
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
        endfunction

        function int unsigned cols();
            if (width_reg < 3) return 3;
            if (width_reg > MAX_W) return MAX_W;
            return int'(width_reg);
        endfunction

        function int unsigned rows();
            return (height_reg == 0) ? 1 : int'(height_reg);
        endfunction

        function bit draining();
            return in_row >= rows();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_COEF_TOP:    coef[0] = val;
                REG_COEF_MIDDLE: coef[1] = val;
                REG_COEF_BOTTOM: coef[2] = val;
                REG_DIVISOR:     divisor = val[7:0];
                REG_FRAME_WIDTH: begin
                    width_reg = val[10:0];
                    restart();
                end
                REG_FRAME_HGT: begin
                    height_reg = val[11:0];
                    restart();
                end
                default: ;
            endcase
        endfunction

        function logic [7:0] filtered();
            logic signed [7:0] cf;
            int sum;
            int q;
            int d;
            sum = 0;
            d = (divisor == 0) ? 1 : int'(divisor);
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) begin
                    cf = coef[i][8*j +: 8];
                    sum += int'(cf) * int'(window[i*3+j]);
                end
            q = sum / d;
            if (q < 0) q = 0;
            if (q > PIX_MAX) q = PIX_MAX;
            return q[7:0];
        endfunction

        function bit step_out(int unsigned w, int unsigned h);
            if (out_row == h - 1 && out_col == w - 1) begin
                restart();
                return 1'b1;
            end
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
            return 1'b0;
        endfunction

        function void note_input(t_in it);
            int unsigned w, h, c, r;
            logic [7:0] corner, val;
            t_out res;
            w = cols();
            h = rows();
            if (it.func == FUNC_DRAIN) begin
                if (!draining()) return;
                c = (out_col < w) ? out_col : 0;
                val = (out_row == h - 1) ? lower_row[c] : upper_row[c];
                res.end_of_frame = step_out(w, h);
                res.out_pixel = val;
                pending.push_back(res);
                return;
            end
            if (draining()) return;
            c = (in_col < w) ? in_col : 0;
            r = in_row;
            corner = upper_row[w-1];
            for (int i = 0; i < 3; i++) begin
                window[i*3]   = window[i*3+1];
                window[i*3+1] = window[i*3+2];
            end
            window[2] = upper_row[c];
            window[5] = lower_row[c];
            window[8] = it.pixel_value;
            upper_row[c] = lower_row[c];
            lower_row[c] = it.pixel_value;
            in_col = c + 1;
            if (in_col >= w) begin
                in_col = 0;
                in_row = r + 1;
            end
            if (!((c >= 1) ? (r >= 1) : (r >= 2))) return;
            if (c == 0)
                val = corner;
            else if (out_row >= 1 && out_row + 2 <= h && out_col >= 1 && out_col + 2 <= w)
                val = filtered();
            else
                val = window[4];
            res.end_of_frame = step_out(w, h);
            res.out_pixel = val;
            pending.push_back(res);
        endfunction

        function void check_output(t_out got);
            t_out exp_res;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: pixel %0d eof %0d",
                             got.out_pixel, got.end_of_frame);
                return;
            end
            exp_res = pending.pop_front();
            checked++;
            if (got.out_pixel !== exp_res.out_pixel ||
                got.end_of_frame !== exp_res.end_of_frame) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: pixel exp %0d got %0d, eof exp %0d got %0d",
                             checked, exp_res.out_pixel, got.out_pixel,
                             exp_res.end_of_frame, got.end_of_frame);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in                   i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out                  o_out_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    filter_board board = new();
    int  cycles;
    bit  calm;
    int  items_sent;
    int  frames_run;

    convolution_3x3_divide_clamp #(.MAX_WIDTH(MAX_W)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("convolution_3x3_divide_clamp verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= 22);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_output(o_out_data);
    end

    task automatic send(t_in it);
        while (!calm && $urandom_range(99) < 22) begin
            i_in_valid <= 1'b0;
            i_in_data  <= t_in'($urandom);
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_input(it);
        items_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic reconfigure(logic [23:0] top, logic [23:0] mid, logic [23:0] bot,
                               logic [7:0] div, logic [10:0] w, logic [11:0] h);
        logic [CFG_DATA_W-1:0] vals [8];
        vals[0] = top;
        vals[1] = mid;
        vals[2] = bot;
        vals[3] = CFG_DATA_W'(div);
        vals[4] = CFG_DATA_W'(w);
        vals[5] = CFG_DATA_W'(h);
        vals[6] = CFG_DATA_W'($urandom);
        vals[7] = CFG_DATA_W'($urandom);
        for (int k = 0; k < 8; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= k[CFG_IDX_W-1:0];
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
            board.write_reg(k[CFG_IDX_W-1:0], vals[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // abort_after < 0 runs the frame to its end
    task automatic run_frame(int abort_after, int noise);
        t_in it;
        int  k;
        k = 0;
        while (!board.draining()) begin
            if (abort_after >= 0 && k >= abort_after) break;
            it.func = ($urandom_range(99) < noise) ? FUNC_DRAIN : FUNC_PIXEL;
            it.pixel_value = rand_pixel();
            send(it);
            k++;
        end
        if (abort_after < 0) begin
            while (board.draining()) begin
                it.func = ($urandom_range(99) < noise) ? FUNC_PIXEL : FUNC_DRAIN;
                it.pixel_value = 8'($urandom);
                send(it);
            end
        end
        settle();
        frames_run++;
    endtask

    function automatic logic [23:0] rand_coefs();
        case ($urandom_range(7))
            0:       return 24'h808080;
            1:       return 24'h7F7F7F;
            2:       return 24'h000000;
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        t_in it;
        logic [10:0] w;
        logic [11:0] h;
        cycles      = 0;
        items_sent  = 0;
        frames_run  = 0;
        calm        = 1'b0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_ready <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults after reset: a partial row, then an early drain
        for (int k = 0; k < 4; k++) begin
            it.func = FUNC_PIXEL;
            it.pixel_value = (k % 2) ? 8'd255 : 8'd0;
            send(it);
        end
        it.func = FUNC_DRAIN;
        send(it);
        settle();

        // width below range, height zero, extreme coefficients and divisor
        reconfigure(24'h808080, 24'h7F7F7F, 24'h808080, 8'd255, 11'd0, 12'd0);
        run_frame(-1, 0);
        // smallest interior frame, divisor zero, saturating sums
        reconfigure(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 8'd0, 11'd3, 12'd3);
        run_frame(-1, 0);
        reconfigure(24'h808080, 24'h808080, 24'h808080, 8'd1, 11'd3, 12'd3);
        run_frame(-1, 0);
        // width above range: one full row at the widest line, then a few pixels
        reconfigure(rand_coefs(), rand_coefs(), rand_coefs(), 8'd1, 11'd2047, 12'd2);
        run_frame(1030, 0);

        while (items_sent < 1850) begin
            calm = (frames_run >= 8 && frames_run < 14);
            case ($urandom_range(19))
                0: begin
                    w = 11'($urandom_range(2));
                    h = 12'($urandom_range(4));
                end
                1: begin
                    w = 11'($urandom_range(3, 12));
                    h = 12'($urandom_range(1, 5));
                end
                2: begin
                    w = 11'($urandom_range(3, 6));
                    h = 12'd4095;
                end
                default: begin
                    w = 11'($urandom_range(3, 12));
                    h = 12'($urandom_range(0, 6));
                end
            endcase
            reconfigure(rand_coefs(), rand_coefs(), rand_coefs(),
                        ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 40)), w, h);
            if (h == 12'd4095 || $urandom_range(15) == 0)
                run_frame($urandom_range(5, 30), 6);
            else
                run_frame(-1, 6);
        end
        calm = 1'b0;
        settle();

        $display("%0d frames and %0d items sent, %0d results checked, %0d mismatches",
                 frames_run, items_sent, board.checked, board.mismatches);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("convolution_3x3_divide_clamp verification clean");
        else begin
            $display("%0d results never arrived", board.pending.size());
            $display("convolution_3x3_divide_clamp verification failed");
        end
        $finish;
    end

endmodule
